FILE: hdl/satc_pkg.sv
package satc_pkg;

    // Default geometry
    localparam int WAYS_DEF      = 4;
    localparam int SETS_DEF      = 64;
    localparam int OFS_W_DEF     = 4;
    localparam int ADDR_BITS_DEF = 32;

    // Fixed field widths
    localparam int KIND_W       = 1;
    localparam int ADDRESS_W    = 32;
    localparam int SET_NUMBER_W = 6;
    localparam int WAY_NUMBER_W = 2;
    localparam int VICTIM_TAG_W = 22;
    localparam int STAMP_W      = 32;
    localparam int LFSR_W       = 16;

    localparam logic [LFSR_W-1:0]  LFSR_SEED  = 16'hACE1;
    localparam logic [STAMP_W-1:0] STAMP_INIT = 32'd1;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REPLACEMENT    = 2'd0,
        CFG_WB_MODE        = 2'd1,
        CFG_NO_WRITE_ALLOC = 2'd2
    } cfg_reg_t;

    // Victim policy; the spare code behaves as LRU
    typedef enum logic [1:0] {
        REPL_LRU     = 2'd0,
        REPL_FIFO    = 2'd1,
        REPL_RANDOM  = 2'd2,
        REPL_LRU_ALT = 2'd3
    } repl_mode_t;

    typedef struct packed {
        logic                    hit;
        logic                    allocated;
        logic                    compulsory_fill;
        logic [SET_NUMBER_W-1:0] set_number;
        logic [WAY_NUMBER_W-1:0] way_number;
        logic                    evicted;
        logic [VICTIM_TAG_W-1:0] victim_tag;
        logic                    dirty_writeback;
    } resp_t;

    // Side effects of one lookup on the shared counters
    typedef struct packed {
        logic use_inc;
        logic fill_inc;
        logic lfsr_step;
    } upd_t;

endpackage

FILE: hdl/satc_req_if.sv
interface satc_req_if;
    logic                            valid;
    logic                            ready;
    logic [satc_pkg::KIND_W-1:0]     kind;
    logic [satc_pkg::ADDRESS_W-1:0]  address;

    modport source (output valid, output kind, output address, input ready);
    modport sink   (input valid, input kind, input address, output ready);
endinterface

FILE: hdl/satc_resp_if.sv
interface satc_resp_if;
    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic                               allocated;
    logic                               compulsory_fill;
    logic [satc_pkg::SET_NUMBER_W-1:0]  set_number;
    logic [satc_pkg::WAY_NUMBER_W-1:0]  way_number;
    logic                               evicted;
    logic [satc_pkg::VICTIM_TAG_W-1:0]  victim_tag;
    logic                               dirty_writeback;

    modport source (output valid, output hit, output allocated, output compulsory_fill,
                    output set_number, output way_number, output evicted,
                    output victim_tag, output dirty_writeback, input ready);
    modport sink   (input valid, input hit, input allocated, input compulsory_fill,
                    input set_number, input way_number, input evicted,
                    input victim_tag, input dirty_writeback, output ready);
endinterface

FILE: hdl/satc_ram.sv
module satc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read with old data on a collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/satc_lookup.sv
module satc_lookup #(
    parameter int WAYS  = satc_pkg::WAYS_DEF,
    parameter int TAG_W = 22,
    parameter int SET_W = 6,
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int LINE_W = 2 + TAG_W + 2 * satc_pkg::STAMP_W,
    localparam int ROW_W  = WAYS * LINE_W
) (
    input  logic                           is_write,
    input  logic [SET_W-1:0]               set,
    input  logic [TAG_W-1:0]               tag,
    input  logic [ROW_W-1:0]               row_in,
    input  satc_pkg::repl_mode_t           repl_mode,
    input  logic                           wb_mode,
    input  logic                           no_write_alloc,
    input  logic [satc_pkg::STAMP_W-1:0]   use_clock,
    input  logic [satc_pkg::STAMP_W-1:0]   fill_clock,
    input  logic [WAY_W-1:0]               pick,
    output logic [ROW_W-1:0]               row_out,
    output satc_pkg::resp_t                resp,
    output satc_pkg::upd_t                 upd
);

    localparam int SW = satc_pkg::STAMP_W;
    localparam int PW = 1 << WAY_W;

    logic [WAYS-1:0] vld;
    logic [WAYS-1:0] drt;
    logic [TAG_W-1:0] ltag [WAYS];
    logic [SW-1:0]    ustamp [WAYS];
    logic [SW-1:0]    fstamp [WAYS];

    logic             found;
    logic [WAY_W-1:0] hit_way;
    logic             empty;
    logic [WAY_W-1:0] empty_way;
    logic [WAY_W-1:0] lru_way;
    logic [WAY_W-1:0] fifo_way;
    logic [WAY_W-1:0] repl_way;
    logic [WAY_W-1:0] way_sel;
    logic             is_lru;
    logic             is_fifo;
    logic             is_rand;
    logic             allocate;
    logic             evict;

    // Pairwise tree over the stamps; the lower way wins a tie
    function automatic logic [WAY_W-1:0] oldest(input logic [SW-1:0] s [WAYS]);
        logic [SW-1:0]    st [PW];
        logic [WAY_W-1:0] ix [PW];
        for (int i = 0; i < PW; i++)
        begin
            st[i] = '1;
            ix[i] = WAY_W'(i);
        end
        for (int i = 0; i < WAYS; i++)
        begin
            st[i] = s[i];
        end
        for (int lv = 0; lv < WAY_W; lv++)
        begin
            for (int i = 0; i < (PW >> (lv + 1)); i++)
            begin
                if (st[2*i+1] < st[2*i])
                begin
                    st[i] = st[2*i+1];
                    ix[i] = ix[2*i+1];
                end
                else
                begin
                    st[i] = st[2*i];
                    ix[i] = ix[2*i];
                end
            end
        end
        return ix[0];
    endfunction

    // Unpack the set's ways
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            vld[w]    = row_in[w*LINE_W];
            drt[w]    = row_in[w*LINE_W + 1];
            ltag[w]   = row_in[w*LINE_W + 2 +: TAG_W];
            ustamp[w] = row_in[w*LINE_W + 2 + TAG_W +: SW];
            fstamp[w] = row_in[w*LINE_W + 2 + TAG_W + SW +: SW];
        end
    end

    // Compare tags and find the first empty way, lowest way first
    always_comb
    begin
        found     = 1'b0;
        hit_way   = '0;
        empty     = 1'b0;
        empty_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (vld[w] && (ltag[w] == tag))
            begin
                found   = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!vld[w])
            begin
                empty     = 1'b1;
                empty_way = WAY_W'(w);
            end
        end
    end

    assign lru_way  = oldest(ustamp);
    assign fifo_way = oldest(fstamp);

    // Choose the victim by policy
    always_comb
    begin
        is_lru  = 1'b0;
        is_fifo = 1'b0;
        is_rand = 1'b0;
        unique case (repl_mode)
            satc_pkg::REPL_FIFO:
            begin
                repl_way = fifo_way;
                is_fifo  = 1'b1;
            end
            satc_pkg::REPL_RANDOM:
            begin
                repl_way = pick;
                is_rand  = 1'b1;
            end
            satc_pkg::REPL_LRU, satc_pkg::REPL_LRU_ALT:
            begin
                repl_way = lru_way;
                is_lru   = 1'b1;
            end
        endcase
    end

    assign allocate = !found && !(is_write && no_write_alloc);
    assign evict    = allocate && !empty;

    always_comb
    begin
        priority if (found)
        begin
            way_sel = hit_way;
        end
        else if (allocate)
        begin
            way_sel = empty ? empty_way : repl_way;
        end
        else
        begin
            way_sel = '0;
        end
    end

    // Build the updated row
    always_comb
    begin
        row_out = row_in;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == way_sel)
            begin
                if (found)
                begin
                    if (is_write && wb_mode)
                    begin
                        row_out[w*LINE_W + 1] = 1'b1;
                    end
                    if (is_lru)
                    begin
                        row_out[w*LINE_W + 2 + TAG_W +: SW] = use_clock;
                    end
                end
                else if (allocate)
                begin
                    row_out[w*LINE_W]               = 1'b1;
                    row_out[w*LINE_W + 1]           = is_write && wb_mode;
                    row_out[w*LINE_W + 2 +: TAG_W]  = tag;
                    if (is_lru)
                    begin
                        row_out[w*LINE_W + 2 + TAG_W +: SW] = use_clock;
                    end
                    if (is_fifo)
                    begin
                        row_out[w*LINE_W + 2 + TAG_W + SW +: SW] = fill_clock;
                    end
                end
            end
        end
    end

    // Report
    always_comb
    begin
        resp.hit             = found;
        resp.allocated       = allocate;
        resp.compulsory_fill = allocate && empty;
        resp.set_number      = satc_pkg::SET_NUMBER_W'(set);
        resp.way_number      = satc_pkg::WAY_NUMBER_W'(way_sel);
        resp.evicted         = evict;
        resp.victim_tag      = evict ? satc_pkg::VICTIM_TAG_W'(ltag[way_sel]) : '0;
        resp.dirty_writeback = evict && wb_mode && drt[way_sel];
    end

    assign upd.use_inc   = (found || allocate) && is_lru;
    assign upd.fill_inc  = allocate && is_fifo;
    assign upd.lfsr_step = evict && is_rand;

endmodule

FILE: hdl/set_associative_cache_tag_controller_core.sv
// Channel  | Direction | Payload
// req      | in        | kind, address
// resp     | out       | hit, allocated, compulsory_fill, set_number, way_number,
//          |           | evicted, victim_tag, dirty_writeback
// cfg      | in        | cfg_we, cfg_index, cfg_wdata (write only)
//
// One request per cycle while results are taken; the response is registered after the lookup stage.
// Each request reads its set row from the tag RAM at acceptance and writes it
// back when the lookup stage advances; a request to the set just written takes the bypassed row.
// Reset needs no clearing pass: per-set written flags make untouched rows read zero.
// A response not taken holds the lookup stage, and req.ready drops behind it.
module set_associative_cache_tag_controller_core #(
    parameter int WAYS      = satc_pkg::WAYS_DEF,
    parameter int SETS      = satc_pkg::SETS_DEF,
    parameter int OFS_W     = satc_pkg::OFS_W_DEF,
    parameter int ADDR_BITS = satc_pkg::ADDR_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    satc_req_if.sink                           req,
    satc_resp_if.source                        resp,
    input  logic                               cfg_we,
    input  logic [satc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [satc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int SW         = satc_pkg::STAMP_W;
    localparam int LW         = satc_pkg::LFSR_W;
    localparam int IDX_W      = (SETS > 1) ? $clog2(SETS) : 0;
    localparam int SET_W      = (IDX_W > 0) ? IDX_W : 1;
    localparam int TAG_SHIFT  = OFS_W + IDX_W;
    localparam int TAG_W      = (ADDR_BITS > TAG_SHIFT) ? ADDR_BITS - TAG_SHIFT : 1;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINE_W     = 2 + TAG_W + 2 * SW;
    localparam int ROW_W      = WAYS * LINE_W;
    localparam int RECIP      = (1 << LW) / WAYS;
    localparam logic [satc_pkg::ADDRESS_W-1:0] ADDR_MASK =
        satc_pkg::ADDRESS_W'((64'd1 << ADDR_BITS) - 64'd1);

    // One LFSR step, taps 16, 14, 13, 11, shifting right
    function automatic logic [LW-1:0] lfsr_adv(input logic [LW-1:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[LW-1:1]};
    endfunction

    // Value modulo WAYS through a reciprocal and one correction
    function automatic logic [WAY_W-1:0] way_of(input logic [LW-1:0] v);
        logic [2*LW:0]  prod;
        logic [LW-1:0]  q_est;
        logic [LW+4:0]  qd;
        logic [LW:0]    rem;
        prod  = (2*LW+1)'(v) * (2*LW+1)'(RECIP);
        q_est = prod[2*LW-1:LW];
        qd    = (LW+5)'(q_est) * (LW+5)'(WAYS);
        rem   = {1'b0, v} - (LW+1)'(qd);
        if (rem >= (LW+1)'(WAYS))
        begin
            rem = rem - (LW+1)'(WAYS);
        end
        return WAY_W'(rem);
    endfunction

    localparam logic [LW-1:0] LFSR_FIRST = lfsr_adv(satc_pkg::LFSR_SEED);

    // Configuration registers
    satc_pkg::repl_mode_t repl_mode_reg;
    logic                 wb_mode_reg;
    logic                 no_write_alloc_reg;

    // Shared counters
    logic [SW-1:0]    use_clk_reg;
    logic [SW-1:0]    fill_clk_reg;
    logic [LW-1:0]    lfsr_reg;
    logic [WAY_W-1:0] pick_reg;

    // Lookup stage
    logic               stg_vld_reg;
    logic               stg_kind_reg;
    logic [SET_W-1:0]   stg_set_reg;
    logic [TAG_W-1:0]   stg_tag_reg;
    logic               stg_fwd_reg;
    logic               stg_rowok_reg;
    logic [ROW_W-1:0]   fwd_row_reg;
    logic [SETS-1:0]    row_ok_reg;

    // Response register
    logic               res_vld_reg;
    satc_pkg::resp_t    res_reg;

    logic [satc_pkg::ADDRESS_W-1:0] addr_m;
    logic [satc_pkg::ADDRESS_W-1:0] idx_raw;
    logic [SET_W:0]                 set_wide;
    logic [SET_W-1:0]               in_set;
    logic [TAG_W-1:0]               in_tag;
    logic                           in_acc;
    logic                           stg_adv;
    logic                           stg_fwd_next;
    logic [ROW_W-1:0]               ram_rdata;
    logic [ROW_W-1:0]               row_cur;
    logic [ROW_W-1:0]               row_new;
    satc_pkg::resp_t                lk_resp;
    satc_pkg::upd_t                 lk_upd;

    // Split the address into set and tag
    always_comb
    begin
        addr_m  = req.address & ADDR_MASK;
        idx_raw = addr_m >> OFS_W;
        if (IDX_W > 0)
        begin
            set_wide = {1'b0, SET_W'(idx_raw)};
        end
        else
        begin
            set_wide = '0;
        end
        if (set_wide >= (SET_W+1)'(SETS))
        begin
            set_wide = set_wide - (SET_W+1)'(SETS);
        end
        in_set = set_wide[SET_W-1:0];
        in_tag = TAG_W'(addr_m >> TAG_SHIFT);
    end

    // Handshake
    assign stg_adv      = stg_vld_reg && (!res_vld_reg || resp.ready);
    assign req.ready    = !stg_vld_reg || stg_adv;
    assign in_acc       = req.valid && req.ready;
    assign stg_fwd_next = stg_adv && (stg_set_reg == in_set);

    satc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (stg_adv),
        .waddr (stg_set_reg),
        .wdata (row_new),
        .re    (in_acc),
        .raddr (in_set),
        .rdata (ram_rdata)
    );

    // Pick the row: bypassed, stored, or never written
    always_comb
    begin
        priority if (stg_fwd_reg)
        begin
            row_cur = fwd_row_reg;
        end
        else if (stg_rowok_reg)
        begin
            row_cur = ram_rdata;
        end
        else
        begin
            row_cur = '0;
        end
    end

    satc_lookup #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W),
        .SET_W (SET_W)
    ) u_lookup (
        .is_write       (stg_kind_reg),
        .set            (stg_set_reg),
        .tag            (stg_tag_reg),
        .row_in         (row_cur),
        .repl_mode      (repl_mode_reg),
        .wb_mode        (wb_mode_reg),
        .no_write_alloc (no_write_alloc_reg),
        .use_clock      (use_clk_reg),
        .fill_clock     (fill_clk_reg),
        .pick           (pick_reg),
        .row_out        (row_new),
        .resp           (lk_resp),
        .upd            (lk_upd)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_mode_reg      <= satc_pkg::REPL_LRU;
            wb_mode_reg        <= 1'b1;
            no_write_alloc_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                satc_pkg::CFG_REPLACEMENT:
                    repl_mode_reg <= satc_pkg::repl_mode_t'(cfg_wdata[1:0]);
                satc_pkg::CFG_WB_MODE:
                    wb_mode_reg <= cfg_wdata[0];
                satc_pkg::CFG_NO_WRITE_ALLOC:
                    no_write_alloc_reg <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Advance stamps and the LFSR
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_clk_reg  <= satc_pkg::STAMP_INIT;
            fill_clk_reg <= satc_pkg::STAMP_INIT;
            lfsr_reg     <= satc_pkg::LFSR_SEED;
            pick_reg     <= way_of(LFSR_FIRST);
        end
        else if (stg_adv)
        begin
            if (lk_upd.use_inc)
            begin
                use_clk_reg <= use_clk_reg + 1'b1;
            end
            if (lk_upd.fill_inc)
            begin
                fill_clk_reg <= fill_clk_reg + 1'b1;
            end
            if (lk_upd.lfsr_step)
            begin
                lfsr_reg <= lfsr_adv(lfsr_reg);
                pick_reg <= way_of(lfsr_adv(lfsr_adv(lfsr_reg)));
            end
        end
    end

    // Lookup stage control and written-row flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= 1'b0;
            row_ok_reg  <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                stg_vld_reg <= req.valid;
            end
            if (stg_adv)
            begin
                row_ok_reg[stg_set_reg] <= 1'b1;
            end
        end
    end

    // Lookup stage payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            stg_kind_reg  <= req.kind;
            stg_set_reg   <= in_set;
            stg_tag_reg   <= in_tag;
            stg_fwd_reg   <= stg_fwd_next;
            stg_rowok_reg <= row_ok_reg[in_set];
        end
        if (stg_adv)
        begin
            fwd_row_reg <= row_new;
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (stg_adv)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (resp.ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_adv)
        begin
            res_reg <= lk_resp;
        end
    end

    assign resp.valid           = res_vld_reg;
    assign resp.hit             = res_reg.hit;
    assign resp.allocated       = res_reg.allocated;
    assign resp.compulsory_fill = res_reg.compulsory_fill;
    assign resp.set_number      = res_reg.set_number;
    assign resp.way_number      = res_reg.way_number;
    assign resp.evicted         = res_reg.evicted;
    assign resp.victim_tag      = res_reg.victim_tag;
    assign resp.dirty_writeback = res_reg.dirty_writeback;

endmodule

FILE: hdl/satc_checker.sv
module satc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               resp_valid,
    input logic                               resp_ready,
    input logic                               hit,
    input logic                               allocated,
    input logic                               compulsory_fill,
    input logic                               evicted,
    input logic [satc_pkg::VICTIM_TAG_W-1:0]  victim_tag,
    input logic                               dirty_writeback
);

    // A hit never fills a line
    assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid |-> !(hit && allocated))
        else $error("hit and allocation reported together");

    // An eviction is a fill of a way that was already valid
    assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && evicted |-> allocated && !compulsory_fill)
        else $error("eviction without a replacing fill");

    // A dirty write-back needs an eviction
    assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && dirty_writeback |-> evicted)
        else $error("write-back without eviction");

    // No victim tag without an eviction
    assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !evicted |-> victim_tag == '0)
        else $error("victim tag set without eviction");

    // A stalled response stays
    assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |=> resp_valid && $stable(victim_tag))
        else $error("stalled response dropped or changed");

endmodule

bind set_associative_cache_tag_controller_core satc_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .resp_valid      (resp.valid),
    .resp_ready      (resp.ready),
    .hit             (resp.hit),
    .allocated       (resp.allocated),
    .compulsory_fill (resp.compulsory_fill),
    .evicted         (resp.evicted),
    .victim_tag      (resp.victim_tag),
    .dirty_writeback (resp.dirty_writeback)
);

FILE: dv/set_associative_cache_tag_controller_core_tb.sv
module set_associative_cache_tag_controller_core_tb;

    localparam int SET_CNT = satc_pkg::SETS_DEF;
    localparam int WAY_CNT = satc_pkg::WAYS_DEF;
    localparam int OFS_W   = satc_pkg::OFS_W_DEF;
    localparam int SN_W    = satc_pkg::SET_NUMBER_W;
    localparam int VT_W    = satc_pkg::VICTIM_TAG_W;
    localparam int A_W     = satc_pkg::ADDRESS_W;
    localparam int TAG_LSB = OFS_W + SN_W;
    localparam int PHASES  = 7;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct {
        bit                              is_cfg;
        satc_pkg::cfg_reg_t              reg_sel;
        logic [satc_pkg::CFG_DATA_W-1:0] reg_val;
        logic                            kind;
        logic [A_W-1:0]                  address;
        bit                              has_exp;
        satc_pkg::resp_t                 exp;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                             cfg_we;
    logic [satc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [satc_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    satc_req_if  req_ch ();
    satc_resp_if resp_ch ();

    set_associative_cache_tag_controller_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .resp      (resp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the tag store and its policy registers
    logic                         line_ok    [SET_CNT][WAY_CNT];
    logic                         line_mod   [SET_CNT][WAY_CNT];
    logic [VT_W-1:0]              line_tag_s [SET_CNT][WAY_CNT];
    logic [satc_pkg::STAMP_W-1:0] use_age    [SET_CNT][WAY_CNT];
    logic [satc_pkg::STAMP_W-1:0] fill_age   [SET_CNT][WAY_CNT];
    logic [satc_pkg::STAMP_W-1:0] use_tick;
    logic [satc_pkg::STAMP_W-1:0] fill_tick;
    logic [satc_pkg::LFSR_W-1:0]  victim_lfsr;
    satc_pkg::repl_mode_t         policy;
    logic                         wb_on;
    logic                         bypass_writes;

    satc_pkg::resp_t pending_lookups [$];
    stim_row_t dir_rows [$];

    int fail_count = 0;
    int result_count = 0;
    int request_count;
    int hit_count;
    int evict_count;
    int dirty_count;
    int bypass_count;
    int settings_count;

    // Receiver controls
    int  ready_style;
    bit  hold_off_req;
    bit  hold_seen;
    int  hold_left = 0;
    int  rcv_cycle = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Look up one request in the shadow store and apply its side effects
    function automatic satc_pkg::resp_t lookup_line(input logic is_wr,
                                                    input logic [A_W-1:0] a);
        satc_pkg::resp_t      r;
        logic [SN_W-1:0]      s;
        logic [VT_W-1:0]      t;
        satc_pkg::repl_mode_t m;
        int                   way;
        bit                   found;
        bit                   empty;
        r = '0;
        s = a[TAG_LSB-1:OFS_W];
        t = a[A_W-1:TAG_LSB];
        m = (policy == satc_pkg::REPL_LRU_ALT) ? satc_pkg::REPL_LRU : policy;
        found = 1'b0;
        way = 0;
        r.set_number = s;
        for (int w = 0; w < WAY_CNT; w++)
        begin
            if (!found && line_ok[s][w] && line_tag_s[s][w] == t)
            begin
                found = 1'b1;
                way = w;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            r.way_number = way[satc_pkg::WAY_NUMBER_W-1:0];
            if (is_wr && wb_on)
                line_mod[s][way] = 1'b1;
            if (m == satc_pkg::REPL_LRU)
            begin
                use_age[s][way] = use_tick;
                use_tick = use_tick + 1;
            end
        end
        else if (!(is_wr && bypass_writes))
        begin
            r.allocated = 1'b1;
            empty = 1'b0;
            for (int w = 0; w < WAY_CNT; w++)
            begin
                if (!empty && !line_ok[s][w])
                begin
                    empty = 1'b1;
                    way = w;
                end
            end
            if (empty)
                r.compulsory_fill = 1'b1;
            else
            begin
                // Pick the victim; ties go to the lowest way
                if (m == satc_pkg::REPL_RANDOM)
                begin
                    victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3]
                                   ^ victim_lfsr[5], victim_lfsr[satc_pkg::LFSR_W-1:1]};
                    way = int'(victim_lfsr % WAY_CNT);
                end
                else
                begin
                    way = 0;
                    for (int w = 1; w < WAY_CNT; w++)
                    begin
                        if (m == satc_pkg::REPL_FIFO ? fill_age[s][w] < fill_age[s][way]
                                                     : use_age[s][w] < use_age[s][way])
                            way = w;
                    end
                end
                r.evicted = 1'b1;
                r.victim_tag = line_tag_s[s][way];
                r.dirty_writeback = wb_on && line_mod[s][way];
            end
            line_ok[s][way] = 1'b1;
            line_tag_s[s][way] = t;
            line_mod[s][way] = is_wr && wb_on;
            if (m == satc_pkg::REPL_LRU)
            begin
                use_age[s][way] = use_tick;
                use_tick = use_tick + 1;
            end
            else if (m == satc_pkg::REPL_FIFO)
            begin
                fill_age[s][way] = fill_tick;
                fill_tick = fill_tick + 1;
            end
            r.way_number = way[satc_pkg::WAY_NUMBER_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [A_W-1:0] line_addr(input logic [VT_W-1:0] t,
                                                 input logic [SN_W-1:0] s,
                                                 input logic [OFS_W-1:0] o);
        return {t, s, o};
    endfunction

    function automatic satc_pkg::resp_t fixed_resp(input logic h, input logic al,
                                                   input logic cf, input logic [SN_W-1:0] s,
                                                   input logic [satc_pkg::WAY_NUMBER_W-1:0] w,
                                                   input logic ev, input logic [VT_W-1:0] vt,
                                                   input logic dw);
        satc_pkg::resp_t r;
        r.hit = h;
        r.allocated = al;
        r.compulsory_fill = cf;
        r.set_number = s;
        r.way_number = w;
        r.evicted = ev;
        r.victim_tag = vt;
        r.dirty_writeback = dw;
        return r;
    endfunction

    function automatic stim_row_t op_row(input logic k, input logic [A_W-1:0] a);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.reg_sel = satc_pkg::CFG_REPLACEMENT;
        row.reg_val = '0;
        row.kind = k;
        row.address = a;
        row.has_exp = 1'b0;
        row.exp = '0;
        return row;
    endfunction

    function automatic stim_row_t chk_row(input logic k, input logic [A_W-1:0] a,
                                          input satc_pkg::resp_t e);
        stim_row_t row;
        row = op_row(k, a);
        row.has_exp = 1'b1;
        row.exp = e;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input satc_pkg::cfg_reg_t sel,
                                          input logic [satc_pkg::CFG_DATA_W-1:0] v);
        stim_row_t row;
        row = op_row(KIND_READ, '0);
        row.is_cfg = 1'b1;
        row.reg_sel = sel;
        row.reg_val = v;
        return row;
    endfunction

    // Offer one request, hold it until taken, then log what should come back
    task automatic offer_request(input logic k, input logic [A_W-1:0] a,
                                 input bit use_fixed, input satc_pkg::resp_t fixed);
        satc_pkg::resp_t e;
        req_ch.valid <= 1'b1;
        req_ch.kind <= k;
        req_ch.address <= a;
        do
            @(posedge clk);
        while (!req_ch.ready);
        e = lookup_line(k, a);
        if (use_fixed)
            e = fixed;
        pending_lookups.push_back(e);
        request_count++;
        hit_count += e.hit;
        evict_count += e.evicted;
        dirty_count += e.dirty_writeback;
        bypass_count += (!e.hit && !e.allocated);
    endtask

    // Drop valid for a while, with junk on the payload
    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            req_ch.valid <= 1'b0;
            req_ch.kind <= 1'($urandom);
            req_ch.address <= $urandom;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_lookups.size() != 0);
    endtask

    // Write one register; the caller lowers the enable
    task automatic write_reg(input satc_pkg::cfg_reg_t sel,
                             input logic [satc_pkg::CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= v;
        @(posedge clk);
        case (sel)
            satc_pkg::CFG_REPLACEMENT:    policy = satc_pkg::repl_mode_t'(v);
            satc_pkg::CFG_WB_MODE:        wb_on = v[0];
            satc_pkg::CFG_NO_WRITE_ALLOC: bypass_writes = v[0];
            default:                      ;
        endcase
    endtask

    // Random traffic: mostly a few hot sets and a small tag pool, so lines collide
    task automatic run_phase(input int n_items, input bit gaps_on);
        logic [VT_W-1:0]  tag_pool [6];
        logic [SN_W-1:0]  hot_sets [4];
        logic [OFS_W-1:0] off;
        logic [A_W-1:0]   a;
        int               sent;
        int               burst;
        int               gap;
        foreach (tag_pool[i])
            tag_pool[i] = VT_W'($urandom);
        foreach (hot_sets[i])
            hot_sets[i] = SN_W'($urandom);
        sent = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && sent < n_items; b++)
            begin
                off = OFS_W'($urandom);
                if ($urandom_range(0, 9) < 8)
                    a = line_addr(tag_pool[$urandom_range(0, 5)],
                                  hot_sets[$urandom_range(0, 3)], off);
                else
                    a = $urandom;
                offer_request(1'($urandom), a, 1'b0, '0);
                sent++;
            end
            if (!gaps_on || $urandom_range(0, 3) == 0)
                gap = 0;
            else if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(15, 40);
            else
                gap = $urandom_range(1, 8);
            idle_gap(gap);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: result %0d %s expected %0h, got %0h",
                     $time, result_count, name, want, got);
            fail_count++;
        end
    endtask

    // Response side: check each taken result and choose the next ready
    always @(posedge clk)
    begin
        satc_pkg::resp_t want;
        if (!rst_n)
            resp_ch.ready <= 1'b0;
        else
        begin
            if (resp_ch.valid && resp_ch.ready)
            begin
                if (pending_lookups.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding, expected none, got set %0h",
                             $time, resp_ch.set_number);
                    fail_count++;
                end
                else
                begin
                    want = pending_lookups.pop_front();
                    compare_field("hit", want.hit, resp_ch.hit);
                    compare_field("allocated", want.allocated, resp_ch.allocated);
                    compare_field("compulsory_fill", want.compulsory_fill,
                                  resp_ch.compulsory_fill);
                    compare_field("set_number", want.set_number, resp_ch.set_number);
                    compare_field("way_number", want.way_number, resp_ch.way_number);
                    compare_field("evicted", want.evicted, resp_ch.evicted);
                    compare_field("victim_tag", want.victim_tag, resp_ch.victim_tag);
                    compare_field("dirty_writeback", want.dirty_writeback,
                                  resp_ch.dirty_writeback);
                end
                result_count++;
            end
            rcv_cycle++;
            // A toggle of the request starts a long hold-off
            if (hold_off_req != hold_seen)
            begin
                hold_left = 80;
                hold_seen = hold_off_req;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                resp_ch.ready <= 1'b0;
            end
            else
            begin
                case (ready_style)
                    0:       resp_ch.ready <= 1'b1;
                    1:       resp_ch.ready <= 1'($urandom);
                    2:       resp_ch.ready <= (rcv_cycle % 7) < 5;
                    default: resp_ch.ready <= $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    initial
    begin
        #4000000;
        $display("set_associative_cache_tag_controller_core test failed");
        $finish;
    end

    // Per-phase register settings, extremes included
    satc_pkg::repl_mode_t ph_repl [PHASES] = '{
        satc_pkg::REPL_LRU, satc_pkg::REPL_FIFO, satc_pkg::REPL_RANDOM,
        satc_pkg::REPL_LRU_ALT, satc_pkg::REPL_FIFO, satc_pkg::REPL_RANDOM,
        satc_pkg::REPL_LRU};
    logic ph_wb    [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic ph_nwa   [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
    int   ph_style [PHASES] = '{0, 1, 2, 3, 1, 2, 3};

    initial
    begin
        // Hold the request and configuration inputs at known values from time zero
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_READ;
        req_ch.address = '0;
        cfg_we = 1'b0;
        cfg_index = satc_pkg::CFG_REPLACEMENT;
        cfg_wdata = '0;
        ready_style = 1;
        request_count = 0;
        hit_count = 0;
        evict_count = 0;
        dirty_count = 0;
        bypass_count = 0;
        settings_count = 1;

        // Shadow state after reset
        for (int s = 0; s < SET_CNT; s++)
        begin
            for (int w = 0; w < WAY_CNT; w++)
            begin
                line_ok[s][w] = 1'b0;
                line_mod[s][w] = 1'b0;
                line_tag_s[s][w] = '0;
                use_age[s][w] = '0;
                fill_age[s][w] = '0;
            end
        end
        use_tick = satc_pkg::STAMP_INIT;
        fill_tick = satc_pkg::STAMP_INIT;
        victim_lfsr = satc_pkg::LFSR_SEED;
        policy = satc_pkg::REPL_LRU;
        wb_on = 1'b1;
        bypass_writes = 1'b0;

        // Directed rows: fills, hits, a dirty eviction, bypassed writes, every policy
        dir_rows = '{
            chk_row(KIND_READ, line_addr(22'h0, 6'd0, 4'h0),
                    fixed_resp(1'b0, 1'b1, 1'b1, 6'd0, 2'd0, 1'b0, 22'h0, 1'b0)),
            op_row(KIND_READ, line_addr(22'h0, 6'd0, 4'hF)),
            chk_row(KIND_WRITE, 32'hFFFF_FFFF,
                    fixed_resp(1'b0, 1'b1, 1'b1, 6'd63, 2'd0, 1'b0, 22'h0, 1'b0)),
            op_row(KIND_WRITE, line_addr(22'h3F_FFFF, 6'd63, 4'h0)),
            op_row(KIND_READ, line_addr(22'h1, 6'd63, 4'h3)),
            op_row(KIND_READ, line_addr(22'h2, 6'd63, 4'h7)),
            op_row(KIND_READ, line_addr(22'h3, 6'd63, 4'hB)),
            chk_row(KIND_READ, line_addr(22'h4, 6'd63, 4'h0),
                    fixed_resp(1'b0, 1'b1, 1'b0, 6'd63, 2'd0, 1'b1, 22'h3F_FFFF, 1'b1)),
            op_row(KIND_WRITE, line_addr(22'h0, 6'd0, 4'h8)),
            cfg_row(satc_pkg::CFG_NO_WRITE_ALLOC, 2'd1),
            chk_row(KIND_WRITE, line_addr(22'h7, 6'd10, 4'h0),
                    fixed_resp(1'b0, 1'b0, 1'b0, 6'd10, 2'd0, 1'b0, 22'h0, 1'b0)),
            chk_row(KIND_READ, line_addr(22'h7, 6'd10, 4'h0),
                    fixed_resp(1'b0, 1'b1, 1'b1, 6'd10, 2'd0, 1'b0, 22'h0, 1'b0)),
            cfg_row(satc_pkg::CFG_REPLACEMENT, satc_pkg::REPL_LRU_ALT),
            op_row(KIND_WRITE, line_addr(22'h5, 6'd63, 4'h0)),
            op_row(KIND_READ, line_addr(22'h6, 6'd63, 4'h0)),
            op_row(KIND_READ, line_addr(22'h1, 6'd63, 4'h0)),
            cfg_row(satc_pkg::CFG_REPLACEMENT, satc_pkg::REPL_FIFO),
            op_row(KIND_READ, line_addr(22'h8, 6'd63, 4'h0)),
            op_row(KIND_READ, line_addr(22'h9, 6'd63, 4'h0)),
            cfg_row(satc_pkg::CFG_REPLACEMENT, satc_pkg::REPL_RANDOM),
            op_row(KIND_READ, line_addr(22'hA, 6'd63, 4'h0)),
            op_row(KIND_WRITE, line_addr(22'hB, 6'd63, 4'h0)),
            cfg_row(satc_pkg::CFG_WB_MODE, 2'd0),
            op_row(KIND_WRITE, line_addr(22'hC, 6'd63, 4'h0)),
            op_row(KIND_WRITE, line_addr(22'h2, 6'd10, 4'h0)),
            cfg_row(satc_pkg::CFG_NO_WRITE_ALLOC, 2'd0),
            op_row(KIND_WRITE, line_addr(22'hC, 6'd63, 4'h4))
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows; register writes wait for the pipe to empty
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                wait_for_drain();
                write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
                cfg_we <= 1'b0;
                settings_count++;
            end
            else
            begin
                offer_request(dir_rows[i].kind, dir_rows[i].address,
                              dir_rows[i].has_exp, dir_rows[i].exp);
                idle_gap($urandom_range(0, 2));
            end
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            wait_for_drain();
            write_reg(satc_pkg::CFG_REPLACEMENT, ph_repl[p]);
            write_reg(satc_pkg::CFG_WB_MODE, {1'b0, ph_wb[p]});
            write_reg(satc_pkg::CFG_NO_WRITE_ALLOC, {1'b0, ph_nwa[p]});
            cfg_we <= 1'b0;
            settings_count++;
            ready_style = ph_style[p];
            // Stall the response side long enough to back up the request side
            if (p == 1)
                hold_off_req <= !hold_off_req;
            run_phase(250, p != 0);
        end

        wait_for_drain();
        repeat (4) @(posedge clk);

        $display("Ran %0d requests under %0d register settings: %0d hits, %0d evictions,",
                 request_count, settings_count, hit_count, evict_count);
        $display("%0d dirty write-backs, %0d bypassed write misses, %0d results checked.",
                 dirty_count, bypass_count, result_count);
        if (fail_count == 0)
            $display("set_associative_cache_tag_controller_core test passed");
        else
            $display("set_associative_cache_tag_controller_core test failed");
        $finish;
    end

endmodule
